/* sv/tilt_angle_kalman_fusion_unit_macros.svh */
// Assertion macros for the tilt angle fusion unit.
`ifndef TILT_ANGLE_KALMAN_FUSION_UNIT_MACROS_SVH
`define TILT_ANGLE_KALMAN_FUSION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TAKF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TAKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/takf_pkg.sv */
// Shared types, register indexes and helpers of the tilt angle fusion unit.
`default_nettype none

package takf_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_FILTER_MODE  = 3'd0;
	localparam logic [2:0] REG_ANGLE_NOISE  = 3'd1;
	localparam logic [2:0] REG_BIAS_NOISE   = 3'd2;
	localparam logic [2:0] REG_MEAS_NOISE   = 3'd3;
	localparam logic [2:0] REG_TIME_STEP    = 3'd4;
	localparam logic [2:0] REG_BLEND_WEIGHT = 3'd5;

	// Filter mode codes
	localparam logic MODE_KALMAN = 1'b0;
	localparam logic MODE_BLEND  = 1'b1;

	// Register reset values
	localparam logic [30:0] RST_ANGLE_NOISE  = 31'd268435;
	localparam logic [30:0] RST_BIAS_NOISE   = 31'd805306;
	localparam logic [30:0] RST_MEAS_NOISE   = 31'd134217728;
	localparam logic [28:0] RST_TIME_STEP    = 29'd1342177;
	localparam logic [28:0] RST_BLEND_WEIGHT = 29'd5368709;

	// Fixed point: one in Q4.28
	localparam int FRAC_BITS = 28;
	localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;

	// Gain divider sizes
	localparam int DIV_NUM_W = 60;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = 6;

	// Datapath micro-operations, in issue order
	typedef enum logic [3:0] {
		OP_K_ANG  = 4'd0,
		OP_K_P00  = 4'd1,
		OP_K_P01  = 4'd2,
		OP_K_P10  = 4'd3,
		OP_K_P11  = 4'd4,
		OP_K_C10  = 4'd5,
		OP_K_C11  = 4'd6,
		OP_K_C00  = 4'd7,
		OP_K_C01  = 4'd8,
		OP_K_BE   = 4'd9,
		OP_K_AE   = 4'd10,
		OP_B_PRED = 4'd11,
		OP_B_WACC = 4'd12,
		OP_B_MIX  = 4'd13
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul;
		logic wb;
		op_t  op;
		logic div_start;
		logic div_k1;
		logic rate;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mode;
		logic div_done;
		logic out_free;
	} status_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		logic signed [31:0] r;
		if (v > 44'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -44'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/takf_div.sv */
// Restoring divider for the Kalman gains, one quotient bit per cycle.
`default_nettype none

module takf_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [takf_pkg::DIV_NUM_W-1:0]       num,
	input  wire logic [takf_pkg::DIV_DEN_W-1:0]       den,
	output logic                                      done,
	output logic [takf_pkg::DIV_NUM_W-1:0]            quo
);

	logic [takf_pkg::DIV_NUM_W-1:0] num_q;
	logic [takf_pkg::DIV_DEN_W-1:0] rem_q;
	logic [takf_pkg::DIV_DEN_W-1:0] den_q;
	logic [takf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [takf_pkg::DIV_DEN_W:0]   trial;
	logic [takf_pkg::DIV_DEN_W:0]   diff;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[takf_pkg::DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
	end

	// Control: count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= takf_pkg::DIV_CNT_W'(takf_pkg::DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == takf_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the dividend out, the quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[takf_pkg::DIV_DEN_W]) begin
				rem_q <= diff[takf_pkg::DIV_DEN_W-1:0];
				num_q <= {num_q[takf_pkg::DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[takf_pkg::DIV_DEN_W-1:0];
				num_q <= {num_q[takf_pkg::DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

`default_nettype wire

/* sv/takf_dp.sv */
// Datapath: configuration, filter state, shared multiplier and gain divider.
`default_nettype none

module takf_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [30:0]           cfg_data,
	input  wire logic signed [24:0]    accel_tilt,
	input  wire logic signed [27:0]    gyro_rate,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic signed [31:0]         fused_angle,
	output logic signed [31:0]         corrected_rate,
	output logic signed [31:0]         gyro_bias,
	input  wire takf_pkg::cmd_t        cmd,
	output takf_pkg::status_t          status
);

	// Configuration registers
	logic        mode_q;
	logic [30:0] qa_q;
	logic [30:0] qb_q;
	logic [30:0] r_q;
	logic [28:0] dt_q;
	logic [28:0] w_q;

	// Filter state
	logic signed [31:0] ang_q, bias_q, rate_q;
	logic signed [31:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] k0_q, k1_q;
	logic signed [24:0] acc_q;
	logic signed [27:0] gyr_q;
	logic signed [33:0] pred_q;
	logic signed [68:0] sum_q;
	logic signed [68:0] prod_s1;

	// Output register
	logic               out_valid_q;
	logic signed [31:0] out_ang_q, out_rate_q, out_bias_q;

	logic signed [34:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [29:0] dt_s;
	logic signed [32:0] err;
	logic signed [68:0] prod_rnd;
	logic signed [40:0] rnd;
	logic signed [69:0] mix_sum;
	logic signed [41:0] mix_rnd;
	logic signed [32:0] e_var;
	logic               e_pos;
	logic signed [31:0] p_div;
	logic signed [32:0] p_mag;
	logic [takf_pkg::DIV_NUM_W-1:0] div_num;
	logic [takf_pkg::DIV_NUM_W-1:0] div_quo;
	logic               div_done;
	logic signed [31:0] k_new;

	assign dt_s = signed'({1'b0, dt_q});
	assign err  = 33'(acc_q) - 33'(ang_q);

	// Select multiplier operands per micro-operation
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			takf_pkg::OP_K_ANG: begin
				mul_a = 35'(gyr_q) - 35'(bias_q);
				mul_b = 34'(dt_s);
			end
			takf_pkg::OP_K_P00: begin
				mul_a = 35'(signed'({1'b0, qa_q})) - 35'(p01_q) - 35'(p10_q);
				mul_b = 34'(dt_s);
			end
			takf_pkg::OP_K_P01, takf_pkg::OP_K_P10: begin
				mul_a = -35'(p11_q);
				mul_b = 34'(dt_s);
			end
			takf_pkg::OP_K_P11: begin
				mul_a = 35'(signed'({1'b0, qb_q}));
				mul_b = 34'(dt_s);
			end
			takf_pkg::OP_K_C10: begin
				mul_a = 35'(k1_q);
				mul_b = 34'(p00_q);
			end
			takf_pkg::OP_K_C11: begin
				mul_a = 35'(k1_q);
				mul_b = 34'(p01_q);
			end
			takf_pkg::OP_K_C00: begin
				mul_a = 35'(k0_q);
				mul_b = 34'(p00_q);
			end
			takf_pkg::OP_K_C01: begin
				mul_a = 35'(k0_q);
				mul_b = 34'(p01_q);
			end
			takf_pkg::OP_K_BE: begin
				mul_a = 35'(k1_q);
				mul_b = 34'(err);
			end
			takf_pkg::OP_K_AE: begin
				mul_a = 35'(k0_q);
				mul_b = 34'(err);
			end
			takf_pkg::OP_B_PRED: begin
				mul_a = 35'(gyr_q);
				mul_b = 34'(dt_s);
			end
			takf_pkg::OP_B_WACC: begin
				mul_a = 35'(acc_q);
				mul_b = 34'(signed'({1'b0, w_q}));
			end
			takf_pkg::OP_B_MIX: begin
				mul_a = 35'(pred_q);
				mul_b = 34'(signed'({5'b0, takf_pkg::ONE_Q28[28:0]}))
					- 34'(signed'({1'b0, w_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Round to nearest, ties up, and drop the fraction
	always_comb begin
		prod_rnd = prod_s1 + (69'sd1 <<< (takf_pkg::FRAC_BITS - 1));
		rnd      = prod_rnd[68:takf_pkg::FRAC_BITS];
		mix_sum  = 70'(sum_q) + 70'(prod_s1) + (70'sd1 <<< (takf_pkg::FRAC_BITS - 1));
		mix_rnd  = mix_sum[69:takf_pkg::FRAC_BITS];
	end

	// Innovation variance and gain from the divider
	always_comb begin
		e_var   = 33'(signed'({1'b0, r_q})) + 33'(p00_q);
		e_pos   = !e_var[32] && (e_var != '0);
		p_div   = cmd.div_k1 ? p10_q : p00_q;
		p_mag   = p_div[31] ? -33'(p_div) : 33'(p_div);
		div_num = {p_mag[31:0], {takf_pkg::FRAC_BITS{1'b0}}};
		if (!e_pos) begin
			k_new = '0;
		end else if (p_div[31]) begin
			if (div_quo > takf_pkg::DIV_NUM_W'(64'd2147483648)) begin
				k_new = 32'sh8000_0000;
			end else begin
				k_new = -signed'(div_quo[31:0]);
			end
		end else begin
			if (div_quo > takf_pkg::DIV_NUM_W'(64'd2147483647)) begin
				k_new = 32'sh7FFF_FFFF;
			end else begin
				k_new = signed'(div_quo[31:0]);
			end
		end
	end

	takf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (e_var[31:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= takf_pkg::MODE_KALMAN;
			qa_q   <= takf_pkg::RST_ANGLE_NOISE;
			qb_q   <= takf_pkg::RST_BIAS_NOISE;
			r_q    <= takf_pkg::RST_MEAS_NOISE;
			dt_q   <= takf_pkg::RST_TIME_STEP;
			w_q    <= takf_pkg::RST_BLEND_WEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				takf_pkg::REG_FILTER_MODE:  mode_q <= cfg_data[0];
				takf_pkg::REG_ANGLE_NOISE:  qa_q   <= cfg_data;
				takf_pkg::REG_BIAS_NOISE:   qb_q   <= cfg_data;
				takf_pkg::REG_MEAS_NOISE:   r_q    <= cfg_data;
				takf_pkg::REG_TIME_STEP:    dt_q   <= cfg_data[28:0];
				takf_pkg::REG_BLEND_WEIGHT: w_q    <= cfg_data[28:0];
				default: ;
			endcase
		end
	end

	// Multiplier stage and scratch registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= accel_tilt;
			gyr_q <= gyro_rate;
		end
		if (cmd.mul) begin
			prod_s1 <= 69'(mul_a) * 69'(mul_b);
		end
		if (cmd.wb && cmd.op == takf_pkg::OP_B_PRED) begin
			pred_q <= 34'(ang_q) + 34'(rnd);
		end
		if (cmd.wb && cmd.op == takf_pkg::OP_B_WACC) begin
			sum_q <= prod_s1;
		end
	end

	// Write back filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			rate_q <= '0;
			p00_q  <= takf_pkg::ONE_Q28;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= takf_pkg::ONE_Q28;
			k0_q   <= '0;
			k1_q   <= '0;
		end else begin
			if (cmd.wb) begin
				case (cmd.op)
					takf_pkg::OP_K_ANG, takf_pkg::OP_K_AE:
						ang_q <= takf_pkg::sat32(44'(ang_q) + 44'(rnd));
					takf_pkg::OP_K_P00: p00_q <= takf_pkg::sat32(44'(p00_q) + 44'(rnd));
					takf_pkg::OP_K_P01: p01_q <= takf_pkg::sat32(44'(p01_q) + 44'(rnd));
					takf_pkg::OP_K_P10: p10_q <= takf_pkg::sat32(44'(p10_q) + 44'(rnd));
					takf_pkg::OP_K_P11: p11_q <= takf_pkg::sat32(44'(p11_q) + 44'(rnd));
					takf_pkg::OP_K_C10: p10_q <= takf_pkg::sat32(44'(p10_q) - 44'(rnd));
					takf_pkg::OP_K_C11: p11_q <= takf_pkg::sat32(44'(p11_q) - 44'(rnd));
					takf_pkg::OP_K_C00: p00_q <= takf_pkg::sat32(44'(p00_q) - 44'(rnd));
					takf_pkg::OP_K_C01: p01_q <= takf_pkg::sat32(44'(p01_q) - 44'(rnd));
					takf_pkg::OP_K_BE:  bias_q <= takf_pkg::sat32(44'(bias_q) + 44'(rnd));
					takf_pkg::OP_B_MIX: ang_q <= takf_pkg::sat32(44'(mix_rnd));
					default: ;
				endcase
			end
			if (div_done) begin
				if (cmd.div_k1) begin
					k1_q <= k_new;
				end else begin
					k0_q <= k_new;
				end
			end
			if (cmd.rate) begin
				rate_q <= takf_pkg::sat32(44'(gyr_q) - 44'(bias_q));
			end
		end
	end

	// Output register: load wins over a same-cycle take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ang_q  <= ang_q;
			out_rate_q <= rate_q;
			out_bias_q <= bias_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign fused_angle     = out_ang_q;
	assign corrected_rate  = out_rate_q;
	assign gyro_bias       = out_bias_q;
	assign status.mode     = mode_q;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

/* sv/takf_ctrl.sv */
// Controller: sequences the multiply, divide and write-back steps of one sample.
`default_nettype none

module takf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output takf_pkg::cmd_t          cmd,
	input  wire takf_pkg::status_t  status
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b000_0001,
		S_MUL   = 7'b000_0010,
		S_WB    = 7'b000_0100,
		S_DIV   = 7'b000_1000,
		S_DWAIT = 7'b001_0000,
		S_RATE  = 7'b010_0000,
		S_OUT   = 7'b100_0000
	} state_t;

	state_t          state_q;
	takf_pkg::op_t   op_q;
	logic            div_k1_q;
	logic            accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Sequence the micro-operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= takf_pkg::OP_K_ANG;
			div_k1_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= status.mode ? takf_pkg::OP_B_PRED : takf_pkg::OP_K_ANG;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					case (op_q)
						takf_pkg::OP_K_P11: begin
							div_k1_q <= 1'b0;
							state_q  <= S_DIV;
						end
						takf_pkg::OP_K_AE: state_q <= S_RATE;
						takf_pkg::OP_B_MIX: state_q <= S_OUT;
						default: begin
							op_q    <= takf_pkg::op_t'(op_q + 4'd1);
							state_q <= S_MUL;
						end
					endcase
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (status.div_done) begin
						if (div_k1_q) begin
							op_q    <= takf_pkg::OP_K_C10;
							state_q <= S_MUL;
						end else begin
							div_k1_q <= 1'b1;
							state_q  <= S_DIV;
						end
					end
				end
				S_RATE: state_q <= S_OUT;
				S_OUT: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Decode commands
	always_comb begin
		cmd.load      = accept;
		cmd.mul       = (state_q == S_MUL);
		cmd.wb        = (state_q == S_WB);
		cmd.op        = op_q;
		cmd.div_start = (state_q == S_DIV);
		cmd.div_k1    = div_k1_q;
		cmd.rate      = (state_q == S_RATE);
		cmd.out_load  = (state_q == S_OUT) && status.out_free;
	end

endmodule

`default_nettype wire

/* sv/tilt_angle_kalman_fusion_unit.sv */
// Top level of the tilt angle fusion unit: controller, datapath and checks.
//
// Input channel: in_valid/in_ready carry one sample (accel_tilt, gyro_rate).
// Output channel: out_valid/out_ready carry fused_angle, corrected_rate and
// gyro_bias, one result per sample, held in an output register.
// Configuration: cfg_we writes cfg_data to register cfg_index at once.
// One sample is processed at a time. A Kalman sample runs from acceptance
// to the output register through eleven multiply and write-back steps on
// one shared multiplier, two gain divisions on a bit-serial divider, one
// rate step and one output step; the next sample can be taken in the cycle
// after the output step. A complementary sample runs through three multiply
// steps and the output step. in_ready rises together with out_valid.
// A result waiting in the output register does not block acceptance; only
// when a second result is ready and the first is still not taken does the
// block hold in its final step until out_ready frees the register.
// Reset clears the filter state to zero angle and bias with an identity
// covariance, loads the register defaults and empties the output register.
`default_nettype none

module tilt_angle_kalman_fusion_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [30:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [24:0]  accel_tilt,
	input  wire logic signed [27:0]  gyro_rate,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       fused_angle,
	output logic signed [31:0]       corrected_rate,
	output logic signed [31:0]       gyro_bias
);

`include "tilt_angle_kalman_fusion_unit_macros.svh"

	takf_pkg::cmd_t    cmd;
	takf_pkg::status_t status;

	takf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	takf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accel_tilt     (accel_tilt),
		.gyro_rate      (gyro_rate),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.fused_angle    (fused_angle),
		.corrected_rate (corrected_rate),
		.gyro_bias      (gyro_bias),
		.cmd            (cmd),
		.status         (status)
	);

	// A transaction in starts work: the block is busy next cycle
	`TAKF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	// A result appears only at the end of a sample's work
	`TAKF_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready), "result from idle")
	// Commands never overlap
	`TAKF_ASSERT_NOW(a_cmd_exclusive, 1'b1,
		$onehot0({cmd.mul, cmd.wb, cmd.div_start, cmd.rate, cmd.out_load}), "overlapping commands")

endmodule

`default_nettype wire

/* dv/tilt_angle_kalman_fusion_unit_checker.sv */
// Checker for the tilt angle fusion unit: predicts each result and compares it.
`default_nettype none

module tilt_angle_kalman_fusion_unit_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic signed [24:0] accel_tilt,
	input  wire logic signed [27:0] gyro_rate,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [31:0] fused_angle,
	input  wire logic signed [31:0] corrected_rate,
	input  wire logic signed [31:0] gyro_bias,
	output int                      errors,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
		logic signed [31:0] bias;
	} fusion_t;

	// Shadow registers
	logic        mode;
	logic [30:0] q_angle, q_bias, r_meas;
	logic [28:0] dt, weight;

	// Shadow filter state
	logic signed [31:0] est_angle, est_bias, est_rate;
	logic signed [31:0] cov [4];

	fusion_t expected_fusions [$];

	function automatic longint round_q28(longint v);
		return (v + 64'sd134217728) >>> takf_pkg::FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Advance the shadow state by one sample and return the result
	function automatic fusion_t fuse_sample(longint acc, longint gyr);
		fusion_t r;
		longint t, p00, p01, p10, p11, d0, err, e, k0, k1, t0, t1, w, pred, sum;
		t = longint'(dt);
		if (mode == takf_pkg::MODE_KALMAN) begin
			p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
			k0 = 0; k1 = 0;
			est_angle = clip32(longint'(est_angle) + round_q28((gyr - longint'(est_bias)) * t));
			d0 = longint'(q_angle) - p01 - p10;
			p00 = clip32(p00 + round_q28(d0 * t));
			p01 = clip32(p01 + round_q28(-p11 * t));
			p10 = clip32(p10 + round_q28(-p11 * t));
			p11 = clip32(p11 + round_q28(longint'(q_bias) * t));
			err = acc - longint'(est_angle);
			e = longint'(r_meas) + p00;
			// skip the measurement update on a non-positive innovation variance
			if (e > 0) begin
				k0 = clip32((p00 * 64'sd268435456) / e);
				k1 = clip32((p10 * 64'sd268435456) / e);
			end
			t0 = p00;
			t1 = p01;
			cov[0] = clip32(p00 - round_q28(k0 * t0));
			cov[1] = clip32(p01 - round_q28(k0 * t1));
			cov[2] = clip32(p10 - round_q28(k1 * t0));
			cov[3] = clip32(p11 - round_q28(k1 * t1));
			est_angle = clip32(longint'(est_angle) + round_q28(k0 * err));
			est_bias = clip32(longint'(est_bias) + round_q28(k1 * err));
			est_rate = clip32(gyr - longint'(est_bias));
		end else begin
			w = longint'(weight);
			pred = longint'(est_angle) + round_q28(gyr * t);
			sum = w * acc + (64'sd268435456 - w) * pred;
			est_angle = clip32(round_q28(sum));
		end
		r.angle = est_angle;
		r.rate = est_rate;
		r.bias = est_bias;
		return r;
	endfunction

	assign pending = expected_fusions.size();

	// Track registers, predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		fusion_t want;
		if (!arst_n) begin
			mode <= takf_pkg::MODE_KALMAN;
			q_angle <= takf_pkg::RST_ANGLE_NOISE;
			q_bias <= takf_pkg::RST_BIAS_NOISE;
			r_meas <= takf_pkg::RST_MEAS_NOISE;
			dt <= takf_pkg::RST_TIME_STEP;
			weight <= takf_pkg::RST_BLEND_WEIGHT;
			est_angle = '0;
			est_bias = '0;
			est_rate = '0;
			cov[0] = takf_pkg::ONE_Q28; cov[1] = '0; cov[2] = '0; cov[3] = takf_pkg::ONE_Q28;
			expected_fusions.delete();
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					takf_pkg::REG_FILTER_MODE: mode <= cfg_data[0];
					takf_pkg::REG_ANGLE_NOISE: q_angle <= cfg_data;
					takf_pkg::REG_BIAS_NOISE: q_bias <= cfg_data;
					takf_pkg::REG_MEAS_NOISE: r_meas <= cfg_data;
					takf_pkg::REG_TIME_STEP: dt <= cfg_data[28:0];
					takf_pkg::REG_BLEND_WEIGHT: weight <= cfg_data[28:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_fusions.push_back(fuse_sample(accel_tilt, gyro_rate));
			if (out_valid && out_ready) begin
				if (expected_fusions.size() == 0) begin
					$display("%0t: unexpected result angle=%0d rate=%0d bias=%0d",
						$time, fused_angle, corrected_rate, gyro_bias);
					errors <= errors + 1;
				end else begin
					want = expected_fusions.pop_front();
					if (want.angle !== fused_angle || want.rate !== corrected_rate ||
						want.bias !== gyro_bias) begin
						$display("%0t: mismatch expected angle=%0d rate=%0d bias=%0d",
							$time, want.angle, want.rate, want.bias);
						$display("%0t:          actual   angle=%0d rate=%0d bias=%0d",
							$time, fused_angle, corrected_rate, gyro_bias);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* dv/tilt_angle_kalman_fusion_unit_test.sv */
// Testbench top for the tilt angle fusion unit: stimulus, configuration and verdict.
`default_nettype none

module tilt_angle_kalman_fusion_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED     = 3'd6;
	localparam logic [2:0] REG_UNUSED_TOP = 3'd7;
	localparam int ACC_MAX = 11796480;
	localparam int GYR_MAX = 131072000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [30:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [24:0] accel_tilt = '0;
	logic signed [27:0] gyro_rate = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] fused_angle, corrected_rate, gyro_bias;
	int                 errors, pending;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;

	tilt_angle_kalman_fusion_unit dut (.*);
	tilt_angle_kalman_fusion_unit_checker chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tilt_angle_kalman_fusion_unit_test: errors");
		$finish;
	end

	// Stall the result side at random
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Offer one sample and hold it until the transaction
	task automatic send_sample(input logic signed [24:0] acc, input logic signed [27:0] gyr);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		accel_tilt <= acc;
		gyro_rate <= gyr;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Drain all results before touching the registers
	task automatic drain();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [30:0] pick_reg(input logic [30:0] rst_val);
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return rst_val;
			3: return 31'($urandom);
			default: return 31'($urandom_range(rst_val * 4 + 1, rst_val / 4 + 1));
		endcase
	endfunction

	task automatic random_config(input logic m);
		write_reg(takf_pkg::REG_FILTER_MODE, 31'(m));
		write_reg(takf_pkg::REG_ANGLE_NOISE, pick_reg(takf_pkg::RST_ANGLE_NOISE));
		write_reg(takf_pkg::REG_BIAS_NOISE, pick_reg(takf_pkg::RST_BIAS_NOISE));
		write_reg(takf_pkg::REG_MEAS_NOISE, pick_reg(takf_pkg::RST_MEAS_NOISE));
		write_reg(takf_pkg::REG_TIME_STEP, pick_reg(31'(takf_pkg::RST_TIME_STEP)));
		write_reg(takf_pkg::REG_BLEND_WEIGHT, pick_reg(31'(takf_pkg::RST_BLEND_WEIGHT)));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_sample();
		logic signed [24:0] a;
		logic signed [27:0] g;
		if ($urandom_range(9) == 0) begin
			a = 25'($urandom);
			g = 28'($urandom);
		end else begin
			a = 25'($urandom_range(2 * ACC_MAX) - ACC_MAX);
			g = 28'($urandom_range(GYR_MAX / 8) - GYR_MAX / 16);
		end
		send_sample(a, g);
	endtask

	initial begin
		int idle_pct [4];
		int stall_pct [4];
		idle_pct = '{0, 71, 0, 10};
		stall_pct = '{0, 0, 71, 10};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes, every bit both ways
		send_sample(25'(ACC_MAX), 28'(GYR_MAX));
		send_sample(-25'(ACC_MAX), -28'(GYR_MAX));
		send_sample('0, '0);
		send_sample(25'sh0FF_FFFF, 28'sh7FF_FFFF);
		send_sample(25'sh100_0000, 28'sh800_0000);
		send_sample(25'sh155_5555, 28'sh555_5555);
		send_sample(25'sh0AA_AAAA, 28'shAAA_AAAA);
		drain();

		// Directed: complementary mode, weight of zero, one and above one
		write_reg(takf_pkg::REG_FILTER_MODE, 31'(takf_pkg::MODE_BLEND));
		write_reg(takf_pkg::REG_BLEND_WEIGHT, '0);
		cfg_we <= 1'b0;
		send_sample(25'(ACC_MAX), 28'(GYR_MAX));
		drain();
		write_reg(takf_pkg::REG_BLEND_WEIGHT, 31'h1000_0000);
		cfg_we <= 1'b0;
		send_sample(-25'(ACC_MAX), 28'(GYR_MAX));
		drain();
		write_reg(takf_pkg::REG_BLEND_WEIGHT, '1);
		write_reg(takf_pkg::REG_TIME_STEP, '1);
		cfg_we <= 1'b0;
		send_sample(25'(ACC_MAX), -28'(GYR_MAX));
		send_sample(-25'(ACC_MAX), 28'(GYR_MAX));
		drain();

		// Directed: zero time step and measurement noise, maximum noises, unused index
		write_reg(takf_pkg::REG_FILTER_MODE, 31'(takf_pkg::MODE_KALMAN));
		write_reg(takf_pkg::REG_TIME_STEP, '0);
		write_reg(takf_pkg::REG_MEAS_NOISE, '0);
		write_reg(takf_pkg::REG_ANGLE_NOISE, '1);
		write_reg(takf_pkg::REG_BIAS_NOISE, '1);
		write_reg(REG_UNUSED, '1);
		write_reg(REG_UNUSED_TOP, '1);
		cfg_we <= 1'b0;
		send_sample(25'(ACC_MAX), 28'(GYR_MAX));
		send_sample(-25'(ACC_MAX), -28'(GYR_MAX));
		drain();
		write_reg(takf_pkg::REG_TIME_STEP, 31'h1000_0000);
		write_reg(takf_pkg::REG_MEAS_NOISE, '1);
		cfg_we <= 1'b0;
		send_sample(25'(ACC_MAX), 28'(GYR_MAX));
		send_sample('0, -28'(GYR_MAX));
		drain();

		// Random: four idling phases, five register settings each
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int blk = 0; blk < 5; blk++) begin
				if (blk == 0) begin
					write_reg(takf_pkg::REG_FILTER_MODE, 31'(takf_pkg::MODE_KALMAN));
					write_reg(takf_pkg::REG_ANGLE_NOISE, takf_pkg::RST_ANGLE_NOISE);
					write_reg(takf_pkg::REG_BIAS_NOISE, takf_pkg::RST_BIAS_NOISE);
					write_reg(takf_pkg::REG_MEAS_NOISE, takf_pkg::RST_MEAS_NOISE);
					write_reg(takf_pkg::REG_TIME_STEP, 31'(takf_pkg::RST_TIME_STEP));
					write_reg(takf_pkg::REG_BLEND_WEIGHT, 31'(takf_pkg::RST_BLEND_WEIGHT));
					cfg_we <= 1'b0;
					@(posedge clk);
				end else begin
					random_config(($urandom_range(2) == 0) ? takf_pkg::MODE_BLEND
						: takf_pkg::MODE_KALMAN);
				end
				repeat (24) random_sample();
				drain();
			end
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (errors == 0)
			$display("tilt_angle_kalman_fusion_unit_test: clean");
		else
			$display("tilt_angle_kalman_fusion_unit_test: errors");
		$finish;
	end

endmodule

`default_nettype wire
